@@ rtl/core/integer_to_text_formatter_unit_assert.svh @@
// Assertion macros shared by the formatter modules.
`ifndef INTEGER_TO_TEXT_FORMATTER_UNIT_ASSERT_SVH
`define INTEGER_TO_TEXT_FORMATTER_UNIT_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define ITF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ITF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/itf_pkg.sv @@
package itf_pkg;

    localparam int MAX_DIGITS = 64;
    localparam int VAL_W      = 64;
    localparam int MIN_W      = 6;
    localparam int CHAR_W     = 7;
    localparam int DEC_DIGITS = 20;
    localparam int BCD_W      = DEC_DIGITS * 4;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int NDIG_W     = $clog2(DEC_DIGITS + 1);
    localparam int DIDX_W     = $clog2(DEC_DIGITS);
    localparam int CONV_STEPS = VAL_W / 2;
    localparam int STEP_W     = $clog2(CONV_STEPS);

    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_A     = 7'h41;

    localparam logic [1:0] PLUS_NONE  = 2'd0;
    localparam logic [1:0] PLUS_PLUS  = 2'd1;
    localparam logic [1:0] PLUS_SPACE = 2'd2;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             is_signed;
        logic             radix_hex;
        logic [MIN_W-1:0] min_digits;
        logic             pad_zero;
        logic [1:0]       plus_mode;
        logic             sign_left;
    } t_in_beat;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } t_out_beat;

    typedef struct packed {
        logic load;
        logic conv;
        logic count;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic in_hex;
        logic conv_done;
        logic emit_done;
    } t_sts;

endpackage

@@ rtl/core/itf_datapath.sv @@
`include "integer_to_text_formatter_unit_assert.svh"

module itf_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  itf_pkg::t_in_beat i_in_data,
    input  itf_pkg::t_cmd     i_cmd,
    output itf_pkg::t_sts     o_sts,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output itf_pkg::t_out_beat o_out_data
);
    import itf_pkg::*;

    logic [BCD_W-1:0]  r_bcd;
    logic [VAL_W-1:0]  r_mag;
    logic [STEP_W-1:0] r_step;
    logic              r_pad_zero;
    logic              r_sign_left;
    logic              r_has_sign;
    logic [CHAR_W-1:0] r_sign_ch;
    logic [CNT_W-1:0]  r_min;
    logic [NDIG_W-1:0] r_ndig;
    logic [CNT_W-1:0]  r_pad;
    logic [CNT_W-1:0]  r_total;
    logic [CNT_W-1:0]  r_pos;
    logic [DIDX_W-1:0] r_didx;
    logic              r_ov;
    t_out_beat         r_out;

    // one shift-add-3 step: adjust every digit, then shift in one bit
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b, input logic bit_in);
        logic [BCD_W-1:0] adj;
        adj = b;
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (b[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = b[i*4 +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    function automatic logic [CHAR_W-1:0] glyph(input logic [3:0] d);
        if (d < 4'd10) begin
            return CH_ZERO + CHAR_W'(d);
        end
        return CH_A + CHAR_W'(d - 4'd10);
    endfunction

    // load
    logic              w_neg;
    logic [VAL_W-1:0]  w_mag;
    logic [CNT_W-1:0]  w_min_ext;
    logic [CNT_W-1:0]  w_min_c;
    logic [CHAR_W-1:0] w_sign_ch;
    logic              w_has_sign;

    assign w_neg     = i_in_data.is_signed & i_in_data.value[VAL_W-1];
    assign w_mag     = w_neg ? (~i_in_data.value + 1'b1) : i_in_data.value;
    assign w_min_ext = CNT_W'(i_in_data.min_digits);
    assign w_min_c   = (w_min_ext > CNT_W'(MAX_DIGITS - 1)) ? CNT_W'(MAX_DIGITS - 1) : w_min_ext;

    always_comb begin
        w_has_sign = 1'b1;
        w_sign_ch  = CH_MINUS;
        if (!w_neg) begin
            case (i_in_data.plus_mode)
                PLUS_PLUS:  w_sign_ch = CH_PLUS;
                PLUS_SPACE: w_sign_ch = CH_SPACE;
                default: begin
                    w_sign_ch  = CH_SPACE;
                    w_has_sign = 1'b0;
                end
            endcase
        end
    end

    // conversion
    logic [BCD_W-1:0] w_bcd1;
    logic [BCD_W-1:0] w_bcd2;

    assign w_bcd1 = dabble(r_bcd, r_mag[VAL_W-1]);
    assign w_bcd2 = dabble(w_bcd1, r_mag[VAL_W-2]);

    // digit count
    logic [NDIG_W-1:0] w_ndig;
    logic [CNT_W-1:0]  w_ndig_ext;
    logic [CNT_W-1:0]  w_body;
    logic [CNT_W:0]    w_sum;
    logic [CNT_W-1:0]  w_total;

    always_comb begin
        w_ndig = NDIG_W'(1);
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] != 4'd0) begin
                w_ndig = NDIG_W'(i + 1);
            end
        end
    end

    assign w_ndig_ext = CNT_W'(w_ndig);
    assign w_body     = (r_min > w_ndig_ext) ? r_min : w_ndig_ext;
    assign w_sum      = {1'b0, w_body} + (CNT_W + 1)'(r_has_sign);
    assign w_total    = (w_sum > (CNT_W + 1)'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS)
                                                           : w_sum[CNT_W-1:0];

    // emission
    logic              w_free;
    logic              w_fire;
    logic [CNT_W-1:0]  w_dstart;
    logic              w_is_digit;
    logic              w_is_sign;
    logic              w_last;
    logic [CHAR_W-1:0] w_char;

    assign w_free     = !r_ov || !i_out_stall;
    assign w_fire     = i_cmd.emit && w_free;
    assign w_dstart   = r_pad + CNT_W'(r_has_sign);
    assign w_is_digit = (r_pos >= w_dstart);
    assign w_is_sign  = r_has_sign && (r_sign_left ? (r_pos == '0) : (r_pos == r_pad));
    assign w_last     = (r_pos == r_total - 1'b1);

    always_comb begin
        if (w_is_digit) begin
            w_char = glyph(r_bcd[{r_didx, 2'b00} +: 4]);
        end else if (w_is_sign) begin
            w_char = r_sign_ch;
        end else begin
            w_char = r_pad_zero ? CH_ZERO : CH_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pad_zero  <= i_in_data.pad_zero;
            r_sign_left <= i_in_data.sign_left;
            r_has_sign  <= w_has_sign;
            r_sign_ch   <= w_sign_ch;
            r_min       <= w_min_c;
            r_mag       <= w_mag;
            r_step      <= '0;
            r_bcd       <= i_in_data.radix_hex ? BCD_W'(w_mag) : '0;
        end
        if (i_cmd.conv) begin
            r_bcd  <= w_bcd2;
            r_mag  <= {r_mag[VAL_W-3:0], 2'b00};
            r_step <= r_step + 1'b1;
        end
        if (i_cmd.count) begin
            r_ndig  <= w_ndig;
            r_pad   <= (r_min > w_ndig_ext) ? (r_min - w_ndig_ext) : '0;
            r_total <= w_total;
            r_pos   <= '0;
            r_didx  <= DIDX_W'(w_ndig - 1'b1);
        end
        if (w_fire) begin
            r_pos <= r_pos + 1'b1;
            if (w_is_digit && r_didx != '0) begin
                r_didx <= r_didx - 1'b1;
            end
            r_out.char_code <= w_char;
            r_out.last_char <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_fire) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    assign o_sts.in_hex    = i_in_data.radix_hex;
    assign o_sts.conv_done = (r_step == STEP_W'(CONV_STEPS - 1));
    assign o_sts.emit_done = w_fire && w_last;
    assign o_out_valid     = r_ov;
    assign o_out_data      = r_out;

    `ITF_ASSERT(a_digit_in_range, i_clk, i_rst_n,
        (w_fire && w_is_digit) |-> (NDIG_W'(r_didx) < r_ndig), "digit index past digit count")
    `ITF_ASSERT(a_ndig_valid, i_clk, i_rst_n,
        i_cmd.count |=> (r_ndig != '0 && r_ndig <= NDIG_W'(DEC_DIGITS)), "bad digit count")
    `ITF_ASSERT(a_out_hold, i_clk, i_rst_n,
        (r_ov && i_out_stall) |=> (r_ov && $stable(r_out)), "stalled beat changed")

endmodule

@@ rtl/core/itf_controller.sv @@
`include "integer_to_text_formatter_unit_assert.svh"

module itf_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  itf_pkg::t_sts i_sts,
    output itf_pkg::t_cmd o_cmd
);
    import itf_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CONV  = 2'd1;
    localparam logic [1:0] S_COUNT = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.in_hex ? S_COUNT : S_CONV;
                end
            end
            S_CONV: begin
                if (i_sts.conv_done) begin
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.emit_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // no beat is taken while reset is held
    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign o_cmd.load  = !o_in_stall && i_in_valid;
    assign o_cmd.conv  = (r_state == S_CONV);
    assign o_cmd.count = (r_state == S_COUNT);
    assign o_cmd.emit  = (r_state == S_EMIT);

    `ITF_ASSERT(a_load_next, i_clk, i_rst_n,
        o_cmd.load |=> (r_state == S_CONV || r_state == S_COUNT), "load did not start work")
    `ITF_ASSERT(a_done_idle, i_clk, i_rst_n,
        (o_cmd.emit && i_sts.emit_done) |=> (r_state == S_IDLE), "no return after last beat")
    `ITF_ASSERT_NEVER(a_emit_done_stray, i_clk, i_rst_n,
        i_sts.emit_done && !o_cmd.emit, "last beat outside emit")

endmodule

@@ rtl/core/integer_to_text_formatter_unit.sv @@
// Channel   Direction  Handshake               Payload
// in        input      i_in_valid / o_in_stall  i_in_data  (itf_pkg::t_in_beat)
// out       output     o_out_valid / i_out_stall o_out_data (itf_pkg::t_out_beat)
//
// One number at a time. Decimal: accept, conversion (shift-add-3, two bits per cycle),
// digit count, then one character per cycle while the output is not stalled; hex skips
// conversion. Each number emits N characters, N from 1 to 64.
// Synchronous active-low reset clears the controller and the output valid.
// A stall while a character is valid holds the character register and pauses emission;
// input is taken only when idle and out of reset.
module integer_to_text_formatter_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  itf_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output itf_pkg::t_out_beat o_out_data
);
    import itf_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    itf_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    itf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ verif/integer_to_text_formatter_unit_checker.sv @@
module integer_to_text_formatter_unit_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  itf_pkg::t_in_beat  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  itf_pkg::t_out_beat i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import itf_pkg::*;

    t_out_beat text_q[$];
    int        mismatches = 0;
    int        pending_cnt = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_cnt;

    // Render one number into its character stream and queue the beats.
    task automatic queue_text(input t_in_beat b);
        logic              negative;
        logic [VAL_W-1:0]  mag;
        logic [VAL_W-1:0]  rem;
        logic [VAL_W-1:0]  radix;
        logic [3:0]        d;
        logic [CHAR_W-1:0] digit_chars[MAX_DIGITS];
        logic [CHAR_W-1:0] sign_ch;
        logic [CHAR_W-1:0] text[$];
        int                ndig;
        int                min_cnt;
        int                pad;
        t_out_beat         ob;

        negative = b.is_signed && b.value[VAL_W-1];
        // two's complement negate also covers the most negative value (-2^63)
        mag   = negative ? (~b.value + 64'd1) : b.value;
        radix = b.radix_hex ? 64'd16 : 64'd10;
        ndig  = 0;
        rem   = mag;
        do begin
            d   = 4'(rem % radix);
            rem = rem / radix;
            if (ndig < MAX_DIGITS) begin
                digit_chars[ndig] = (d < 4'd10) ? CH_ZERO + CHAR_W'(d)
                                                : CH_A + CHAR_W'(d - 4'd10);
                ndig++;
            end
        end while (rem != 0);

        min_cnt = int'(b.min_digits);
        if (min_cnt > MAX_DIGITS - 1)
            min_cnt = MAX_DIGITS - 1;
        pad = (min_cnt > ndig) ? min_cnt - ndig : 0;

        sign_ch = '0;
        if (negative)
            sign_ch = CH_MINUS;
        else if (b.plus_mode == PLUS_PLUS)
            sign_ch = CH_PLUS;
        else if (b.plus_mode == PLUS_SPACE)
            sign_ch = CH_SPACE;

        if (b.sign_left && sign_ch != '0)
            text.push_back(sign_ch);
        repeat (pad)
            text.push_back(b.pad_zero ? CH_ZERO : CH_SPACE);
        if (!b.sign_left && sign_ch != '0)
            text.push_back(sign_ch);
        for (int i = ndig - 1; i >= 0; i--)
            text.push_back(digit_chars[i]);
        while (text.size() > MAX_DIGITS)
            void'(text.pop_back());

        foreach (text[i]) begin
            ob.char_code = text[i];
            ob.last_char = (i == text.size() - 1);
            text_q.push_back(ob);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_beat want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall)
                queue_text(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (text_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected char beat code=%h last=%b",
                                 $realtime, i_out_data.char_code, i_out_data.last_char);
                end else begin
                    want = text_q.pop_front();
                    if (want.char_code !== i_out_data.char_code ||
                        want.last_char !== i_out_data.last_char) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: char beat mismatch exp code=%h last=%b, %s",
                                     $realtime, want.char_code, want.last_char,
                                     $sformatf("got code=%h last=%b",
                                               i_out_data.char_code,
                                               i_out_data.last_char));
                    end
                end
            end
        end
        pending_cnt = text_q.size();
    end

endmodule

@@ verif/integer_to_text_formatter_unit_tb.sv @@
module integer_to_text_formatter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itf_pkg::*;

    localparam int         RANDOM_ITEMS = 130;
    localparam int         CYCLE_LIMIT  = 2_000_000;
    localparam int         DRAIN_CYCLES = 120;
    localparam logic [1:0] PLUS_UNUSED  = 2'd3;
    localparam logic       RADIX_DEC    = 1'b0;
    localparam logic       RADIX_HEX    = 1'b1;
    localparam logic       PAD_SPACE    = 1'b0;
    localparam logic       PAD_ZERO     = 1'b1;
    localparam logic       SIGN_INNER   = 1'b0;
    localparam logic       SIGN_OUTER   = 1'b1;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_beat o_out_data;
    int        fail_count;
    int        pending;
    int        cycles = 0;

    integer_to_text_formatter_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    integer_to_text_formatter_unit_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("integer_to_text_formatter_unit_tb: errors");
            $finish;
        end
    end

    function automatic t_in_beat fmt_req(input logic [VAL_W-1:0] v, input logic sgn,
                                         input logic hex, input logic [MIN_W-1:0] mn,
                                         input logic pz, input logic [1:0] pm,
                                         input logic sl);
        t_in_beat b;
        b.value      = v;
        b.is_signed  = sgn;
        b.radix_hex  = hex;
        b.min_digits = mn;
        b.pad_zero   = pz;
        b.plus_mode  = pm;
        b.sign_left  = sl;
        return b;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 64'($urandom_range(0, 999));
            1: return {$urandom, $urandom};
            2: return -64'($urandom_range(1, 5000));
            3: begin
                case ($urandom_range(0, 7))
                    0: return '1;
                    1: return 64'h8000_0000_0000_0000;
                    2: return 64'h7FFF_FFFF_FFFF_FFFF;
                    3: return '0;
                    4: return 64'd10000000000000000000;
                    5: return 64'd9999999999999999999;
                    6: return 64'h1000_0000_0000_0000;
                    default: return 64'h0FFF_FFFF_FFFF_FFFF;
                endcase
            end
            4: return 64'($urandom);
            default: return {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
    endfunction

    function automatic logic [MIN_W-1:0] pick_min();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return MIN_W'($urandom_range(0, 8));
        if (r < 85) return MIN_W'($urandom_range(9, 24));
        return MIN_W'($urandom_range(25, 63));
    endfunction

    // Valid stays high across back-to-back beats; a gap drops it first.
    task automatic send_number(input t_in_beat b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // First let the checker queue the last accepted beat, then wait for no pending text.
    task automatic drain_text();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Output backpressure: free runs, short stalls, the odd long one.
    initial begin : out_stall_gen
        int free;
        int hold;
        int r;
        i_out_stall <= 1'b0;
        forever begin
            free = ($urandom_range(0, 99) < 25) ? $urandom_range(30, 200)
                                                 : $urandom_range(1, 6);
            r = $urandom_range(0, 99);
            hold = (r < 60) ? $urandom_range(1, 3) :
                   (r < 90) ? $urandom_range(4, 8) : $urandom_range(20, 60);
            repeat (free) begin
                @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            repeat (hold) begin
                @(posedge i_clk);
                i_out_stall <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, sign placement, padding, both radices
        send_number(fmt_req('0, 1'b0, RADIX_DEC, 6'd0, PAD_SPACE, PLUS_NONE, SIGN_OUTER));
        send_number(fmt_req('1, 1'b0, RADIX_DEC, 6'd0, PAD_SPACE, PLUS_NONE, SIGN_OUTER));
        send_number(fmt_req('1, 1'b0, RADIX_HEX, 6'd0, PAD_ZERO, PLUS_PLUS, SIGN_OUTER));
        send_number(fmt_req(64'h8000_0000_0000_0000, 1'b1, RADIX_DEC, 6'd0, PAD_SPACE,
                            PLUS_NONE, SIGN_OUTER));
        send_number(fmt_req(64'h8000_0000_0000_0000, 1'b1, RADIX_HEX, 6'd63, PAD_ZERO,
                            PLUS_PLUS, SIGN_OUTER));
        send_number(fmt_req(64'h8000_0000_0000_0000, 1'b0, RADIX_DEC, 6'd0, PAD_SPACE,
                            PLUS_PLUS, SIGN_INNER));
        send_number(fmt_req('1, 1'b1, RADIX_DEC, 6'd0, PAD_SPACE, PLUS_PLUS, SIGN_OUTER));
        send_number(fmt_req(64'd42, 1'b1, RADIX_DEC, 6'd6, PAD_SPACE, PLUS_PLUS, SIGN_INNER));
        send_number(fmt_req(64'd42, 1'b1, RADIX_DEC, 6'd6, PAD_ZERO, PLUS_SPACE, SIGN_OUTER));
        send_number(fmt_req(64'd42, 1'b0, RADIX_DEC, 6'd6, PAD_ZERO, PLUS_SPACE, SIGN_INNER));
        send_number(fmt_req(64'd7, 1'b1, RADIX_DEC, 6'd3, PAD_ZERO, PLUS_UNUSED, SIGN_OUTER));
        send_number(fmt_req('0, 1'b0, RADIX_DEC, 6'd63, PAD_SPACE, PLUS_PLUS, SIGN_INNER));
        send_number(fmt_req(64'hABCD_EF01_2345_6789, 1'b0, RADIX_HEX, 6'd20, PAD_ZERO,
                            PLUS_NONE, SIGN_OUTER));
        send_number(fmt_req(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, RADIX_DEC, 6'd0, PAD_SPACE,
                            PLUS_SPACE, SIGN_OUTER));
        send_number(fmt_req(64'd5, 1'b0, RADIX_DEC, 6'd1, PAD_ZERO, PLUS_NONE, SIGN_OUTER));
        send_number(fmt_req(64'd123456, 1'b1, RADIX_DEC, 6'd6, PAD_ZERO, PLUS_PLUS,
                            SIGN_INNER));
        send_number(fmt_req('0, 1'b1, RADIX_HEX, 6'd0, PAD_SPACE, PLUS_SPACE, SIGN_INNER));
        send_number(fmt_req(-64'd255, 1'b1, RADIX_HEX, 6'd4, PAD_ZERO, PLUS_NONE,
                            SIGN_INNER));
        send_number(fmt_req(-64'd255, 1'b1, RADIX_HEX, 6'd4, PAD_SPACE, PLUS_SPACE,
                            SIGN_OUTER));
        send_number(fmt_req(64'd10000000000000000000, 1'b0, RADIX_DEC, 6'd21, PAD_SPACE,
                            PLUS_UNUSED, SIGN_INNER));
        send_number(fmt_req('1, 1'b0, RADIX_HEX, 6'd63, PAD_SPACE, PLUS_SPACE, SIGN_INNER));
        drain_text();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                drain_text();
            send_number(fmt_req(pick_value(), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), pick_min(),
                                1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                                1'($urandom_range(0, 1))));
        end

        drain_text();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("integer_to_text_formatter_unit_tb: clean");
        else
            $display("integer_to_text_formatter_unit_tb: errors");
        $finish;
    end

endmodule

@@ integer_to_text_formatter_unit.f @@
+incdir+rtl/core
rtl/core/itf_pkg.sv
rtl/core/itf_datapath.sv
rtl/core/itf_controller.sv
rtl/core/integer_to_text_formatter_unit.sv
verif/integer_to_text_formatter_unit_checker.sv
verif/integer_to_text_formatter_unit_tb.sv
